>>> rtl/ring_fifo_with_window_sum_assert.svh
// Assertion macros shared by the ring FIFO modules.
`ifndef RING_FIFO_WITH_WINDOW_SUM_ASSERT_SVH
`define RING_FIFO_WITH_WINDOW_SUM_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RFWS_ASSERT_IMPL(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define RFWS_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/rfws_pkg.sv
// Shared constants, codes and control types of the ring FIFO with window sum.
`default_nettype none

package rfws_pkg;

  localparam int DEPTH_DEFAULT = 256;
  localparam int CAP_RESET     = 256;
  localparam int CAP_MAX       = 511;

  localparam int CMD_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int WIN_W    = 9;
  localparam int CFG_W    = 9;
  localparam int STATUS_W = 2;
  localparam int DATA_W   = 40;
  localparam int LEN_W    = 9;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 56;

  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WSUM = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SUM  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  // Commands from controller to datapath.
  typedef struct packed {
    logic take;
    logic exec;
    logic clr_wr;
    logic sum_rd;
    logic out_load;
  } ctrl_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic go_sum;
    logic clr_last;
    logic rem_last;
  } stat_t;

endpackage

`default_nettype wire

>>> rtl/rfws_dp.sv
// Datapath of the ring FIFO: entry memory, pointers, counters, accumulator, result register.
`default_nettype none
`include "ring_fifo_with_window_sum_assert.svh"

module rfws_dp #(
  parameter int DEPTH = rfws_pkg::DEPTH_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [rfws_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire logic [rfws_pkg::CMD_W-1:0]     in_cmd,
  input  wire logic [rfws_pkg::VALUE_W-1:0]   in_value,
  input  wire logic [rfws_pkg::WIN_W-1:0]     in_wstart,
  input  wire logic [rfws_pkg::WIN_W-1:0]     in_wlen,
  input  wire rfws_pkg::ctrl_t                ctrl,
  output rfws_pkg::stat_t                     stat,
  output logic [rfws_pkg::STATUS_W-1:0]       res_status,
  output logic [rfws_pkg::DATA_W-1:0]         res_data,
  output logic [rfws_pkg::LEN_W-1:0]          res_length,
  output logic                                res_full,
  output logic                                res_empty
);

  // Only slots below the effective capacity are ever touched.
  localparam int USED    = (DEPTH < rfws_pkg::CAP_MAX) ? DEPTH : rfws_pkg::CAP_MAX;
  localparam int PTR_W   = $clog2(USED);
  localparam int CNT_W   = $clog2(USED + 1);
  localparam int RST_CAP = (DEPTH < rfws_pkg::CAP_RESET) ? DEPTH : rfws_pkg::CAP_RESET;
  localparam int SPAN_W  = rfws_pkg::WIN_W + 1;
  localparam int EXT_W   = rfws_pkg::DATA_W - rfws_pkg::VALUE_W;

  logic [rfws_pkg::VALUE_W-1:0] mem [USED];
  logic [rfws_pkg::VALUE_W-1:0] rdata;

  logic [CNT_W-1:0]              cap_eff;
  logic [CNT_W-1:0]              count;
  logic [PTR_W-1:0]              head;
  logic [PTR_W-1:0]              tail;
  logic [PTR_W-1:0]              clr_idx;
  logic [PTR_W-1:0]              idx;
  logic [rfws_pkg::WIN_W-1:0]    rem;
  logic [rfws_pkg::DATA_W-1:0]   acc;
  logic                          sum_pend;
  logic                          res_pop;
  logic [rfws_pkg::STATUS_W-1:0] res_code;

  logic [rfws_pkg::CMD_W-1:0]    cmd_q;
  logic [rfws_pkg::VALUE_W-1:0]  value_q;
  logic [rfws_pkg::WIN_W-1:0]    wstart_q;
  logic [rfws_pkg::WIN_W-1:0]    wlen_q;

  logic [rfws_pkg::STATUS_W-1:0] code;
  logic                          is_sum;
  logic                          push_ok;
  logic                          pop_ok;
  logic [SPAN_W-1:0]             win_end;
  logic [rfws_pkg::WIN_W-1:0]    sum_len;
  logic [SPAN_W-1:0]             start_base;
  logic [SPAN_W-1:0]             start_wrap;
  logic [SPAN_W-1:0]             ptr_span;

  logic                          mem_we;
  logic [PTR_W-1:0]              mem_wa;
  logic [rfws_pkg::VALUE_W-1:0]  mem_wd;
  logic                          mem_re;
  logic [PTR_W-1:0]              mem_ra;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p,
                                               input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] nx;
    nx = CNT_W'(p) + 1'b1;
    return (nx == cap) ? '0 : PTR_W'(nx);
  endfunction

  function automatic logic [CNT_W-1:0] cap_clamp(input logic [rfws_pkg::CFG_W-1:0] v);
    logic [rfws_pkg::CFG_W-1:0] c;
    c = v;
    if (v == '0) begin
      c = rfws_pkg::CFG_W'(1);
    end else if (v > rfws_pkg::CFG_W'(USED)) begin
      c = rfws_pkg::CFG_W'(USED);
    end
    return CNT_W'(c);
  endfunction

  // Command evaluation on the latched word.
  always_comb begin
    win_end = SPAN_W'(wstart_q) + SPAN_W'(wlen_q);
    is_sum  = (cmd_q == rfws_pkg::CMD_WSUM) || (cmd_q == rfws_pkg::CMD_SUM);
    priority if (cmd_q == rfws_pkg::CMD_PUSH) begin
      code = (count == cap_eff) ? rfws_pkg::ST_FULL : rfws_pkg::ST_OK;
    end else if (count == '0) begin
      code = rfws_pkg::ST_EMPTY;
    end else if ((cmd_q == rfws_pkg::CMD_WSUM) && (win_end > SPAN_W'(count))) begin
      code = rfws_pkg::ST_RANGE;
    end else begin
      code = rfws_pkg::ST_OK;
    end
    push_ok = (cmd_q == rfws_pkg::CMD_PUSH) && (code == rfws_pkg::ST_OK);
    pop_ok  = (cmd_q == rfws_pkg::CMD_POP) && (code == rfws_pkg::ST_OK);
    sum_len = (cmd_q == rfws_pkg::CMD_SUM) ? rfws_pkg::WIN_W'(count) : wlen_q;
    start_base = SPAN_W'(head) +
                 ((cmd_q == rfws_pkg::CMD_SUM) ? '0 : SPAN_W'(wstart_q));
    // head < cap and start <= cap, so one subtract wraps it
    start_wrap = (start_base >= SPAN_W'(cap_eff)) ? start_base - SPAN_W'(cap_eff)
                                                  : start_base;
    ptr_span = SPAN_W'(head) + SPAN_W'(count);
  end

  always_comb begin
    stat.go_sum   = (code == rfws_pkg::ST_OK) && is_sum && (sum_len != '0);
    stat.clr_last = (CNT_W'(clr_idx) == cap_eff - 1'b1);
    stat.rem_last = (rem == rfws_pkg::WIN_W'(1));
  end

  // Memory port selection.
  always_comb begin
    mem_we = ctrl.clr_wr || (ctrl.exec && push_ok);
    mem_wa = ctrl.clr_wr ? clr_idx : tail;
    mem_wd = ctrl.clr_wr ? '0 : value_q;
    mem_re = ctrl.sum_rd || (ctrl.exec && pop_ok);
    mem_ra = ctrl.sum_rd ? idx : head;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata <= mem[mem_ra];
    end
  end

  // Queue state; a capacity write refills with zeros.
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_eff <= CNT_W'(RST_CAP);
      count   <= CNT_W'(RST_CAP);
      head    <= '0;
      tail    <= '0;
      clr_idx <= '0;
    end else if (cfg_we) begin
      cap_eff <= cap_clamp(cfg_wdata);
      count   <= cap_clamp(cfg_wdata);
      head    <= '0;
      tail    <= '0;
      clr_idx <= '0;
    end else begin
      if (ctrl.clr_wr) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (ctrl.exec && push_ok) begin
        tail  <= ptr_inc(tail, cap_eff);
        count <= count + 1'b1;
      end
      if (ctrl.exec && pop_ok) begin
        head  <= ptr_inc(head, cap_eff);
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_pend <= 1'b0;
    end else begin
      sum_pend <= ctrl.sum_rd;
    end
  end

  // Input latch, sum walk and accumulator.
  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      cmd_q    <= in_cmd;
      value_q  <= in_value;
      wstart_q <= in_wstart;
      wlen_q   <= in_wlen;
    end
    if (ctrl.exec) begin
      res_code <= code;
      res_pop  <= pop_ok;
      idx      <= PTR_W'(start_wrap);
      rem      <= sum_len;
    end else if (ctrl.sum_rd) begin
      idx <= ptr_inc(idx, cap_eff);
      rem <= rem - 1'b1;
    end
    if (ctrl.exec) begin
      acc <= '0;
    end else if (sum_pend) begin
      acc <= acc + {{EXT_W{rdata[rfws_pkg::VALUE_W-1]}}, rdata};
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      res_status <= res_code;
      res_data   <= res_pop ? {{EXT_W{rdata[rfws_pkg::VALUE_W-1]}}, rdata} : acc;
      res_length <= rfws_pkg::LEN_W'(count);
      res_full   <= (count == cap_eff);
      res_empty  <= (count == '0);
    end
  end

  `RFWS_ASSERT_IMPL(a_count_cap, clk, rst, 1'b1, count <= cap_eff, "count above capacity")
  `RFWS_ASSERT_IMPL(a_ptr_span, clk, rst, 1'b1, (ptr_span == SPAN_W'(tail)) || (ptr_span == SPAN_W'(tail) + SPAN_W'(cap_eff)), "tail not head plus count")
  `RFWS_ASSERT_IMPL(a_clr_range, clk, rst, ctrl.clr_wr, CNT_W'(clr_idx) < cap_eff, "clear index past capacity")

endmodule

`default_nettype wire

>>> rtl/rfws_ctrl.sv
// Controller of the ring FIFO: clear pass, command sequencing and result handoff.
`default_nettype none
`include "ring_fifo_with_window_sum_assert.svh"

module rfws_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  input  wire rfws_pkg::stat_t stat,
  output rfws_pkg::ctrl_t      ctrl
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_SUM   = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign out_free  = !out_tvalid || out_tready;
  assign in_tready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    ctrl          = '0;
    unique case (state)
      S_CLEAR: begin
        ctrl.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          ctrl.take  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        ctrl.exec  = 1'b1;
        state_next = stat.go_sum ? S_SUM : S_OUT;
      end
      S_SUM: begin
        ctrl.sum_rd = 1'b1;
        if (stat.rem_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        // hold the result until the output register frees up
        if (out_free) begin
          ctrl.out_load = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
    if (cfg_we) begin
      state_next = S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      out_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.out_load) begin
        out_tvalid <= 1'b1;
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
    end
  end

  `RFWS_ASSERT_NEXT(a_cfg_clear, clk, rst, cfg_we, state == S_CLEAR, "no clear pass after capacity write")
  `RFWS_ASSERT_NEXT(a_take_busy, clk, rst, ctrl.take && !cfg_we, (state == S_EXEC) && !in_tready, "second word taken while busy")
  `RFWS_ASSERT_NEXT(a_load_valid, clk, rst, ctrl.out_load, out_tvalid, "loaded result not presented")

endmodule

`default_nettype wire

>>> rtl/ring_fifo_with_window_sum.sv
// Top level of the ring FIFO with window and total sums.
`default_nettype none

// Circular queue of signed 32-bit words that starts, after reset and after
// every capacity write, full of "capacity" zeros (0 acts as 1, values above
// DEPTH act as DEPTH). Each input word is one command and gives one result
// word with status, data, length and full/empty flags. Push, pop, every
// error and a window sum of length zero go from execution straight to the
// result; any other window sum and a sum of all entries first walk their
// entries, which are read one per cycle through the single read port of
// the entry memory. After reset and after each capacity write a clearing
// pass writes zeros to every slot below the effective capacity, and no
// command is accepted meanwhile. The next command is taken while a
// finished result still waits on the output side. DEPTH may range from 2
// to 65536; at most 511 slots are ever used.
module ring_fifo_with_window_sum #(
  parameter int DEPTH = rfws_pkg::DEPTH_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [rfws_pkg::CFG_W-1:0]          cfg_wdata,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // value[31:0], window_start[40:32], window_len[49:41], zero pad
  input  wire logic [rfws_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // cmd[1:0]
  input  wire logic [rfws_pkg::CMD_W-1:0]          s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // data[39:0], length[48:40], is_full[49], is_empty[50], zero pad
  output logic [rfws_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
  // status[1:0]
  output logic [rfws_pkg::STATUS_W-1:0]            m_axis_tuser
);

  localparam int WS_LO  = rfws_pkg::VALUE_W;
  localparam int WL_LO  = WS_LO + rfws_pkg::WIN_W;
  localparam int OUT_USED = rfws_pkg::DATA_W + rfws_pkg::LEN_W + 2;

  rfws_pkg::ctrl_t              ctrl;
  rfws_pkg::stat_t              stat;
  logic [rfws_pkg::DATA_W-1:0]  res_data;
  logic [rfws_pkg::LEN_W-1:0]   res_length;
  logic                         res_full;
  logic                         res_empty;

  rfws_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .in_tvalid  (s_axis_tvalid),
    .in_tready  (s_axis_tready),
    .out_tvalid (m_axis_tvalid),
    .out_tready (m_axis_tready),
    .stat       (stat),
    .ctrl       (ctrl)
  );

  rfws_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_cmd     (s_axis_tuser),
    .in_value   (s_axis_tdata[rfws_pkg::VALUE_W-1:0]),
    .in_wstart  (s_axis_tdata[WS_LO +: rfws_pkg::WIN_W]),
    .in_wlen    (s_axis_tdata[WL_LO +: rfws_pkg::WIN_W]),
    .ctrl       (ctrl),
    .stat       (stat),
    .res_status (m_axis_tuser),
    .res_data   (res_data),
    .res_length (res_length),
    .res_full   (res_full),
    .res_empty  (res_empty)
  );

  assign m_axis_tdata = {{(rfws_pkg::OUT_TDATA_W - OUT_USED){1'b0}},
                         res_empty, res_full, res_length, res_data};

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the ring FIFO with window and total sums.
`timescale 1ns / 1ps

module tb_top;
  import rfws_pkg::*;

  localparam int DEPTH       = DEPTH_DEFAULT;
  localparam int STALL_LIMIT = 4000;
  localparam int SEG_ITEMS   = 62;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] value;
    logic [WIN_W-1:0]   wstart;
    logic [WIN_W-1:0]   wlen;
  } fifo_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] data;
    logic [LEN_W-1:0]         length;
    logic                     full;
    logic                     empty;
  } fifo_resp_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_W-1:0]       cfg_wdata = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [CMD_W-1:0]       s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]    m_axis_tuser;

  ring_fifo_with_window_sum dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Queue contents as the predictor sees them
  logic [VALUE_W-1:0] slot_mem [0:DEPTH-1];
  int                 q_head;
  int                 q_tail;
  int                 q_count;
  logic [CFG_W-1:0]   cap_reg;

  fifo_cmd_t  cmd_queue[$];
  fifo_resp_t expected_resp[$];
  fifo_cmd_t  cur_cmd;
  bit         word_taken = 1'b0;
  int         mismatches = 0;
  int         stall_cycles = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;

  // Occupancy as the stimulus generator tracks it
  int gen_count;
  int gen_cap;

  function automatic int clamp_capacity(logic [CFG_W-1:0] c);
    if (c == 0) return 1;
    if (int'(c) > DEPTH) return DEPTH;
    return int'(c);
  endfunction

  function automatic void refill_queue();
    for (int i = 0; i < DEPTH; i++) slot_mem[i] = '0;
    q_head  = 0;
    q_count = clamp_capacity(cap_reg);
    q_tail  = q_count % clamp_capacity(cap_reg);
  endfunction

  function automatic logic signed [DATA_W-1:0] window_total(int first, int n, int cap);
    logic signed [DATA_W-1:0] acc;
    int idx;
    acc = '0;
    idx = (q_head + first) % cap;
    for (int i = 0; i < n; i++) begin
      acc += {{(DATA_W-VALUE_W){slot_mem[idx][VALUE_W-1]}}, slot_mem[idx]};
      idx = (idx + 1) % cap;
    end
    return acc;
  endfunction

  function automatic fifo_resp_t fifo_execute(fifo_cmd_t c);
    fifo_resp_t r;
    int cap;
    cap = clamp_capacity(cap_reg);
    r = '0;
    r.status = ST_OK;
    if (c.cmd == CMD_PUSH) begin
      if (q_count >= cap) begin
        r.status = ST_FULL;
      end else begin
        slot_mem[q_tail] = c.value;
        q_tail = (q_tail + 1) % cap;
        q_count++;
      end
    end else if (q_count == 0) begin
      r.status = ST_EMPTY;
    end else if (c.cmd == CMD_POP) begin
      r.data = {{(DATA_W-VALUE_W){slot_mem[q_head][VALUE_W-1]}}, slot_mem[q_head]};
      q_head = (q_head + 1) % cap;
      q_count--;
    end else if (c.cmd == CMD_WSUM) begin
      if (int'(c.wstart) + int'(c.wlen) > q_count) r.status = ST_RANGE;
      else r.data = window_total(int'(c.wstart), int'(c.wlen), cap);
    end else begin
      r.data = window_total(0, q_count, cap);
    end
    r.length = q_count[LEN_W-1:0];
    r.full   = (q_count == cap);
    r.empty  = (q_count == 0);
    return r;
  endfunction

  task automatic check_resp(input fifo_resp_t got);
    fifo_resp_t want;
    if (expected_resp.size() == 0) begin
      $error("result word with no command pending: status %0d data %0d",
             got.status, $signed(got.data));
      mismatches++;
    end else begin
      want = expected_resp.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.data !== want.data) begin
        $error("data: expected %0d, got %0d", $signed(want.data), $signed(got.data));
        mismatches++;
      end
      if (got.length !== want.length) begin
        $error("length: expected %0d, got %0d", want.length, got.length);
        mismatches++;
      end
      if (got.full !== want.full) begin
        $error("is_full: expected %0d, got %0d", want.full, got.full);
        mismatches++;
      end
      if (got.empty !== want.empty) begin
        $error("is_empty: expected %0d, got %0d", want.empty, got.empty);
        mismatches++;
      end
    end
  endtask

  // Monitor: sample both sides and the register port at the rising edge
  always @(posedge clk) begin
    fifo_resp_t got;
    if (rst) begin
      cap_reg = CFG_W'(CAP_RESET);
      refill_queue();
    end else begin
      if (cfg_we) begin
        cap_reg = cfg_wdata;
        refill_queue();
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tuser;
        got.data   = m_axis_tdata[39:0];
        got.length = m_axis_tdata[48:40];
        got.full   = m_axis_tdata[49];
        got.empty  = m_axis_tdata[50];
        check_resp(got);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_resp.push_back(fifo_execute(cur_cmd));
        word_taken = 1'b1;
      end
    end
  end

  // Driver: advance to the next word only once the current one is taken
  always @(negedge clk) begin
    if (!rst && (!s_axis_tvalid || word_taken)) begin
      if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_cmd = cmd_queue.pop_front();
        s_axis_tdata  <= {6'b0, cur_cmd.wlen, cur_cmd.wstart, cur_cmd.value};
        s_axis_tuser  <= cur_cmd.cmd;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    word_taken = 1'b0;
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic void add_cmd(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] value,
                                  int wstart, int wlen);
    fifo_cmd_t c;
    c.cmd    = cmd;
    c.value  = value;
    c.wstart = WIN_W'(wstart);
    c.wlen   = WIN_W'(wlen);
    cmd_queue.push_back(c);
    if (cmd == CMD_PUSH && gen_count < gen_cap) gen_count++;
    else if (cmd == CMD_POP && gen_count > 0) gen_count--;
  endfunction

  task automatic wait_drained();
    while (cmd_queue.size() != 0 || s_axis_tvalid || expected_resp.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_capacity(input int c);
    wait_drained();
    cfg_wdata <= CFG_W'(c);
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    gen_cap   = clamp_capacity(CFG_W'(c));
    gen_count = gen_cap;
  endtask

  task automatic queue_random(input int n);
    int r;
    int wl;
    int ws;
    logic [VALUE_W-1:0] v;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      v = $urandom;
      if ($urandom_range(7) == 0) v = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      if (r < 8) begin
        // noise: any command with any window fields
        add_cmd(CMD_W'($urandom_range(3)), v, $urandom_range(511), $urandom_range(511));
      end else if (r < 48) begin
        add_cmd(CMD_PUSH, v, $urandom_range(511), $urandom_range(511));
      end else if (r < 83) begin
        add_cmd(CMD_POP, v, $urandom_range(511), $urandom_range(511));
      end else if (r < 93) begin
        if ($urandom_range(9) == 0) wl = $urandom_range(gen_count);
        else wl = $urandom_range(gen_count < 8 ? gen_count : 8);
        if ($urandom_range(7) == 0) ws = gen_count - wl + 1 + $urandom_range(3);
        else ws = $urandom_range(gen_count - wl);
        add_cmd(CMD_WSUM, v, ws, wl);
      end else begin
        add_cmd(CMD_SUM, v, $urandom_range(511), $urandom_range(511));
      end
    end
  endtask

  int cap_plan[12] = '{511, 0, 2, 5, 256, 16, 3, 300, 1, 40, 7, 128};

  initial begin
    gen_cap   = CAP_RESET;
    gen_count = CAP_RESET;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Reset state: full of zeros at the reset capacity
    add_cmd(CMD_PUSH, 32'd1, 0, 0);
    add_cmd(CMD_WSUM, 32'd0, 256, 0);
    add_cmd(CMD_WSUM, 32'd0, 0, 256);
    add_cmd(CMD_WSUM, 32'd0, 1, 256);
    add_cmd(CMD_WSUM, 32'd0, 511, 511);
    add_cmd(CMD_POP, 32'd0, 0, 0);
    add_cmd(CMD_PUSH, 32'h7FFF_FFFF, 0, 0);
    add_cmd(CMD_PUSH, 32'h8000_0000, 0, 0);

    // Single entry: empty checks win over the range check
    write_capacity(1);
    add_cmd(CMD_POP, 32'd0, 0, 0);
    add_cmd(CMD_POP, 32'd0, 0, 0);
    add_cmd(CMD_WSUM, 32'd0, 511, 511);
    add_cmd(CMD_SUM, 32'd0, 0, 0);
    add_cmd(CMD_PUSH, 32'h8000_0000, 0, 0);
    add_cmd(CMD_PUSH, 32'd5, 0, 0);
    add_cmd(CMD_SUM, 32'd0, 0, 0);
    add_cmd(CMD_WSUM, 32'd0, 0, 1);
    add_cmd(CMD_WSUM, 32'd0, 1, 0);
    add_cmd(CMD_WSUM, 32'd0, 0, 2);
    add_cmd(CMD_POP, 32'd0, 0, 0);

    // Window that wraps around the end of the ring
    write_capacity(3);
    add_cmd(CMD_POP, 32'd0, 0, 0);
    add_cmd(CMD_POP, 32'd0, 0, 0);
    add_cmd(CMD_PUSH, 32'h7FFF_FFFF, 0, 0);
    add_cmd(CMD_PUSH, 32'h7FFF_FFFF, 0, 0);
    add_cmd(CMD_WSUM, 32'd0, 1, 2);
    add_cmd(CMD_SUM, 32'd0, 0, 0);

    for (int p = 0; p < 3; p++) begin
      wait_drained();
      send_idle_pct = (p == 0) ? 22 : (p == 1) ? 85 : 0;
      recv_idle_pct = (p == 0) ? 85 : (p == 1) ? 22 : 0;
      for (int s = 0; s < 4; s++) begin
        write_capacity(cap_plan[p*4 + s]);
        queue_random(SEG_ITEMS);
      end
    end

    wait_drained();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && expected_resp.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
